@@ src/pal_pkg.sv @@
`timescale 1ns / 1ps
// pal_pkg: command and response beat types, command kinds and status codes
// shared by the positional array list cells, gather tree and top level
// no dependencies
package pal_pkg;

  // wide enough for any position or count up to a capacity of 4096
  localparam int unsigned POS_W = 13;
  // cells per first-level group of the removal gather tree
  localparam int unsigned GROUP_SIZE = 64;

  typedef enum logic [2:0] {
    KIND_INS_HEAD = 3'd0,
    KIND_INS_TAIL = 3'd1,
    KIND_INS_POS  = 3'd2,
    KIND_REM_HEAD = 3'd3,
    KIND_REM_TAIL = 3'd4,
    KIND_REM_POS  = 3'd5
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_EMPTY  = 2'd2,
    ST_BADPOS = 2'd3
  } status_e;

  typedef struct packed {
    logic [2:0]  kind;
    logic [10:0] position;
    logic [31:0] entry_data;
  } pal_cmd_t;

  typedef struct packed {
    status_e     status;
    logic [31:0] removed_data;
    logic [10:0] count_after;
  } pal_rsp_t;

  // broadcast to every cell: which shift to do and where
  typedef struct packed {
    logic             ins;
    logic             rem;
    logic [POS_W-1:0] target;
  } pal_ctrl_t;

endpackage

@@ src/pal_cell.sv @@
`timescale 1ns / 1ps
// pal_cell: one list slot, shifts up from or down to its neighbours
// depends on pal_pkg
module pal_cell import pal_pkg::*; #(
  parameter int unsigned DATA_WIDTH = 32,
  parameter int unsigned IDX        = 0
) (
  input  logic                  clk_i,
  input  pal_ctrl_t             ctrl_i,
  input  logic [DATA_WIDTH-1:0] data_i,
  input  logic [DATA_WIDTH-1:0] prev_i,
  input  logic [DATA_WIDTH-1:0] next_i,
  output logic [DATA_WIDTH-1:0] entry_o,
  output logic [DATA_WIDTH-1:0] sel_o
);

  localparam logic [POS_W-1:0] MyIdx = POS_W'(IDX);

  logic [DATA_WIDTH-1:0] entry_q, entry_d;
  logic                  above, at;

  assign above = MyIdx > ctrl_i.target;
  assign at    = MyIdx == ctrl_i.target;

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.ins) begin
      if (above) begin
        entry_d = prev_i;
      end else if (at) begin
        entry_d = data_i;
      end
    end else if (ctrl_i.rem && (above || at)) begin
      entry_d = next_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;
  // word leaving the list, offered to the gather tree
  assign sel_o   = (ctrl_i.rem && at) ? entry_q : '0;

endmodule

@@ src/pal_gather.sv @@
`timescale 1ns / 1ps
// pal_gather: two-level or-tree picking the one selected cell word
// depends on pal_pkg
module pal_gather import pal_pkg::*; #(
  parameter int unsigned CAPACITY   = 1024,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic                                clk_i,
  input  logic                                en_i,
  input  logic [CAPACITY-1:0][DATA_WIDTH-1:0] sel_i,
  output logic [DATA_WIDTH-1:0]               data_o
);

  localparam int unsigned NumGroups = (CAPACITY + GROUP_SIZE - 1) / GROUP_SIZE;

  logic [NumGroups-1:0][DATA_WIDTH-1:0] group_q, group_d;

  always_comb begin
    group_d = '0;
    for (int unsigned g = 0; g < NumGroups; g++) begin
      for (int unsigned k = 0; k < GROUP_SIZE; k++) begin
        if (g * GROUP_SIZE + k < CAPACITY) begin
          group_d[g] = group_d[g] | sel_i[g * GROUP_SIZE + k];
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      group_q <= group_d;
    end
  end

  always_comb begin
    data_o = '0;
    for (int unsigned g = 0; g < NumGroups; g++) begin
      data_o = data_o | group_q[g];
    end
  end

endmodule

@@ src/positional_array_list.sv @@
`timescale 1ns / 1ps
// positional_array_list: bounded ordered list with insert and remove at
// head, tail or position; top level built on pal_cell and pal_gather
// depends on pal_pkg, pal_cell, pal_gather
//
// usage
//   command channel: cmd_valid_i / cmd_ready_o carry one pal_cmd_t beat
//   (kind, position, entry_data); response channel: rsp_valid_o /
//   rsp_ready_i carry one pal_rsp_t beat (status, removed_data,
//   count_after) for every command, in order
//   cfg_we_i writes capacity_limit from cfg_data_i; write it
//   only while no command is outstanding
//   every slot is a cell; all cells shift in parallel on the accepting edge
//   so the list and count are updated at once
//   each command is held in the tree stage, where the registered or-tree
//   fetches the removed word, and then moves into the response register,
//   which drives the response beat
//   the tree stage holds one command at a time, so a new command is taken
//   only after the last one has left the stage
//   the response register parts the two sides: a new command is taken while
//   a response waits; a stalled receiver holds the tree stage and then stops
//   the command channel
//   reset clears the count to zero and the limit to 1024; entry words are
//   not cleared since slots at or above the count are never read
module positional_array_list import pal_pkg::*; #(
  parameter int unsigned CAPACITY   = 1024,
  parameter int unsigned DATA_WIDTH = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cmd_valid_i,
  output logic        cmd_ready_o,
  input  pal_cmd_t    cmd_i,
  output logic        rsp_valid_o,
  input  logic        rsp_ready_i,
  output pal_rsp_t    rsp_o,
  input  logic        cfg_we_i,
  input  logic [10:0] cfg_data_i
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam logic [POS_W-1:0] CapPos = POS_W'(CAPACITY);

  // configuration and list occupancy
  logic [CntW-1:0] count_q, count_d;
  logic [10:0]     limit_q;

  // tree stage and response register
  logic     pending_q;
  status_e  a_status_q, status_d;
  logic [10:0] a_count_q;
  logic     rsp_valid_q;
  pal_rsp_t rsp_q;

  logic             accept, advance;
  logic             is_ins, is_rem, ins_ok, rem_ok;
  logic [POS_W-1:0] cnt, lim, eff_lim, pos, target, cnt_next;
  pal_ctrl_t        ctrl;
  logic [63:0]      data_ext, removed_ext;
  logic [DATA_WIDTH-1:0] ins_data, gathered;

  logic [CAPACITY-1:0][DATA_WIDTH-1:0] entry_w, sel_w;

  assign cmd_ready_o = !pending_q;
  assign accept      = cmd_valid_i && cmd_ready_o;
  assign advance     = pending_q && (!rsp_valid_q || rsp_ready_i);

  assign cnt     = POS_W'(count_q);
  assign lim     = POS_W'(limit_q);
  assign eff_lim = (lim > CapPos) ? CapPos : lim;
  assign pos     = POS_W'(cmd_i.position);

  // decode kind into insert/remove and the slot it targets
  always_comb begin
    is_ins = 1'b0;
    is_rem = 1'b0;
    target = '0;
    case (kind_e'(cmd_i.kind))
      KIND_INS_HEAD: begin
        is_ins = 1'b1;
      end
      KIND_INS_TAIL: begin
        is_ins = 1'b1;
        target = cnt;
      end
      KIND_INS_POS: begin
        is_ins = 1'b1;
        target = pos;
      end
      KIND_REM_HEAD: begin
        is_rem = 1'b1;
      end
      KIND_REM_TAIL: begin
        is_rem = 1'b1;
        target = cnt - POS_W'(1);
      end
      KIND_REM_POS: begin
        is_rem = 1'b1;
        target = pos;
      end
      default: begin
        is_ins = 1'b0;
      end
    endcase
  end

  // error priority: full before bad position, empty before bad position
  always_comb begin
    status_d = ST_OK;
    ins_ok   = 1'b0;
    rem_ok   = 1'b0;
    if (is_ins) begin
      if (cnt >= eff_lim) begin
        status_d = ST_FULL;
      end else if (target > cnt) begin
        status_d = ST_BADPOS;
      end else begin
        ins_ok = 1'b1;
      end
    end else if (is_rem) begin
      if (cnt == '0) begin
        status_d = ST_EMPTY;
      end else if (target >= cnt) begin
        status_d = ST_BADPOS;
      end else begin
        rem_ok = 1'b1;
      end
    end
  end

  assign ctrl.ins    = accept && ins_ok;
  assign ctrl.rem    = accept && rem_ok;
  assign ctrl.target = target;

  always_comb begin
    count_d = count_q;
    if (ctrl.ins) begin
      count_d = count_q + CntW'(1);
    end else if (ctrl.rem) begin
      count_d = count_q - CntW'(1);
    end
  end

  assign cnt_next = POS_W'(count_d);

  assign data_ext = 64'(cmd_i.entry_data);
  assign ins_data = data_ext[DATA_WIDTH-1:0];

  // chain of slots, each fed by its lower and upper neighbour
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] prev_w, next_w;
    if (i == 0) begin : g_first
      assign prev_w = ins_data;
    end else begin : g_mid_lo
      assign prev_w = entry_w[i-1];
    end
    if (i == CAPACITY - 1) begin : g_last
      assign next_w = entry_w[i];
    end else begin : g_mid_hi
      assign next_w = entry_w[i+1];
    end
    pal_cell #(
      .DATA_WIDTH(DATA_WIDTH),
      .IDX       (i)
    ) u_cell (
      .clk_i  (clk_i),
      .ctrl_i (ctrl),
      .data_i (ins_data),
      .prev_i (prev_w),
      .next_i (next_w),
      .entry_o(entry_w[i]),
      .sel_o  (sel_w[i])
    );
  end

  // removed word: all-zero unless a removal succeeded
  pal_gather #(
    .CAPACITY  (CAPACITY),
    .DATA_WIDTH(DATA_WIDTH)
  ) u_gather (
    .clk_i (clk_i),
    .en_i  (accept),
    .sel_i (sel_w),
    .data_o(gathered)
  );

  assign removed_ext = 64'(gathered);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      limit_q     <= 11'd1024;
      pending_q   <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      count_q <= count_d;
      if (cfg_we_i) begin
        limit_q <= cfg_data_i;
      end
      if (accept) begin
        pending_q <= 1'b1;
      end else if (advance) begin
        pending_q <= 1'b0;
      end
      if (advance) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        rsp_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_status_q <= status_d;
      a_count_q  <= cnt_next[10:0];
    end
    if (advance) begin
      rsp_q.status       <= a_status_q;
      rsp_q.removed_data <= removed_ext[31:0];
      rsp_q.count_after  <= a_count_q;
    end
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

  // occupancy never passes the number of cells
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    POS_W'(count_q) <= CapPos)
    else $error("list count above capacity");

  // a shift is either up or down, never both
  a_one_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctrl.ins && ctrl.rem))
    else $error("insert and remove in the same cycle");

  // an accepted insert grows the list by exactly one
  a_ins_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctrl.ins |=> count_q == $past(count_q) + CntW'(1))
    else $error("insert did not grow the count");

  // an error beat carries no removed word
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_o && rsp_o.status != ST_OK) |-> rsp_o.removed_data == '0)
    else $error("error response with removed data");

  // the tree stage holds a command until the response register takes it
  a_stage_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pending_q && rsp_valid_q && !rsp_ready_i) |=> pending_q)
    else $error("tree stage dropped while response stalled");

endmodule
